// File: rtl/core/sorted_table_binary_search_assert.svh
// ---------------------------------------------------------------------------
// sorted table binary search assertion macros
// concurrent checks sampled on clk, held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define STBS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/stbs_pkg.sv
// ---------------------------------------------------------------------------
// stbs_pkg
// shared constants for the sorted table binary search block
// ---------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int DEF_TABLE_DEPTH = 128;
  localparam int DEF_KEY_WIDTH   = 24;

  localparam int SLOT_W          = 7;
  localparam int ENTRY_COUNT_W   = 8;

  localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = 8'd96;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/sorted_table_binary_search.sv
// ---------------------------------------------------------------------------
// sorted_table_binary_search
// membership test on a table of ascending keys by binary search
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one transfer carries cmd, slot, key.
//     a load (cmd 0) writes key into slot and gives no result; a slot at or
//     beyond the table depth is dropped. a query (cmd 1) gives one result.
//   result channel (out_valid/out_ready): one transfer carries found.
//   config channel (cfg_valid/cfg_data): writes entry_count, always ready.
//     counts above the table depth act as the depth, zero means empty.
// sequence
//   a load is written at its transfer and leaves the sequencer idle. a
//   query on a non-empty table passes the low, high, probe and finish
//   states before out_valid, with p probes (at most floor(log2 n)+1);
//   the next item is taken in the cycle the result appears. each probe
//   is one read of the single key memory. a query rejected by the range
//   check ends after the first or second memory read.
// reset and stalls
//   rst_n (synchronous) clears the sequencer and the valid flag and sets
//   entry_count to 96; the key memory keeps no reset value. while the
//   receiver stalls, a finished result waits in the output register and
//   the next item is still taken; a second result waits until it drains.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = stbs_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // item input
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic                               in_cmd,
  input  wire logic [stbs_pkg::SLOT_W-1:0]        in_slot,
  input  wire logic [KEY_WIDTH-1:0]               in_key,
  // result output
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               out_found,
  // entry_count register write
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [stbs_pkg::ENTRY_COUNT_W-1:0] cfg_data
);

  `include "sorted_table_binary_search_assert.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for an item
  localparam logic [2:0] ST_LOW   = 3'd1;  // first entry arriving
  localparam logic [2:0] ST_HIGH  = 3'd2;  // last entry in use arriving
  localparam logic [2:0] ST_PROBE = 3'd3;  // centre entry arriving
  localparam logic [2:0] ST_FIN   = 3'd4;  // answer ready for the output reg

  // key memory, one write port and one registered read port
  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [IDX_W-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0] rd_data_r;

  logic [2:0]                         state_r, state_nxt;
  logic [KEY_WIDTH-1:0]               key_r, key_nxt;
  logic [IDX_W:0]                     lo_r, lo_nxt;
  logic [IDX_W:0]                     hi_r, hi_nxt;
  logic [IDX_W:0]                     ctr_r, ctr_nxt;
  logic                               found_r, found_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_found_r, out_found_nxt;
  logic [stbs_pkg::ENTRY_COUNT_W-1:0] count_r;

  logic           in_fire;
  logic           load_ok;
  logic [31:0]    slot_ext;
  logic [31:0]    n_ext;
  logic [31:0]    hi_init;
  logic           probe_lt;
  logic           probe_eq;
  logic [IDX_W:0] lo_step;
  logic [IDX_W:0] hi_step;
  logic           step_empty;
  logic [IDX_W+1:0] mid_sum;
  logic [IDX_W+1:0] step_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  // loads beyond the table depth are dropped
  assign slot_ext = 32'(in_slot);
  assign load_ok  = in_fire && (in_cmd == stbs_pkg::CMD_LOAD) &&
                    (slot_ext < 32'(TABLE_DEPTH));

  // entries in use, saturated at the depth
  assign n_ext   = (32'(count_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(count_r);
  assign hi_init = n_ext - 32'd1;

  // probe compare and the next interval
  assign probe_lt   = rd_data_r < key_r;
  assign probe_eq   = rd_data_r == key_r;
  assign lo_step    = probe_lt ? (ctr_r + 1'b1) : lo_r;
  assign hi_step    = probe_lt ? hi_r : (ctr_r - 1'b1);
  // going left from slot zero leaves an empty interval
  assign step_empty = (lo_step > hi_step) || (!probe_lt && (ctr_r == '0));
  assign step_sum   = {1'b0, lo_step} + {1'b0, hi_step};
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ctr_nxt       = ctr_r;
    found_nxt     = found_r;
    rd_addr       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;

    case (state_r)
      ST_IDLE: begin
        // the read of slot zero goes out with the query transfer
        if (in_fire && (in_cmd == stbs_pkg::CMD_QUERY)) begin
          key_nxt = in_key;
          lo_nxt  = '0;
          hi_nxt  = hi_init[IDX_W:0];
          if (n_ext == 32'd0) begin
            found_nxt = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_LOW;
          end
        end
      end
      ST_LOW: begin
        rd_addr = hi_r[IDX_W-1:0];
        if (key_r < rd_data_r) begin
          found_nxt = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_HIGH;
        end
      end
      ST_HIGH: begin
        ctr_nxt = mid_sum[IDX_W+1:1];
        rd_addr = ctr_nxt[IDX_W-1:0];
        if (key_r > rd_data_r) begin
          found_nxt = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        ctr_nxt = step_sum[IDX_W+1:1];
        rd_addr = ctr_nxt[IDX_W-1:0];
        if (probe_eq) begin
          found_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else if (step_empty) begin
          found_nxt = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          lo_nxt = lo_step;
          hi_nxt = hi_step;
        end
      end
      ST_FIN: begin
        // hand over once the output register is free or draining
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // key memory
  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[slot_ext[IDX_W-1:0]] <= in_key;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= stbs_pkg::ENTRY_COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ctr_r       <= ctr_nxt;
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
  end

  // a query transfer occupies the sequencer
  `STBS_ASSERT_NEXT(a_query_busy, in_fire && (in_cmd == stbs_pkg::CMD_QUERY), !in_ready, "query transfer did not leave idle")
  // results only come from a finished search
  `STBS_ASSERT_SAME(a_result_src, $rose(out_valid_r), $past(state_r) == ST_FIN, "result raised outside finish")
  // every probe lies inside a non-empty interval
  `STBS_ASSERT_SAME(a_probe_range, state_r == ST_PROBE, (lo_r <= ctr_r) && (ctr_r <= hi_r), "probe outside search interval")
  // a load never creates a result
  `STBS_ASSERT_NEXT(a_load_silent, load_ok && !out_valid_r, !out_valid_r, "load produced a result")

endmodule

`default_nettype wire
